// File: rtl/bole_pkg.sv
// Shared constants for the bounded ordered list engine: request kinds,
// status codes, field widths and register map. No dependencies.
package bole_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int KIND_W = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W = 4;
    localparam int CAP_W = 4;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd3;

    localparam logic [KIND_W-1:0] K_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] K_REM_REAR = 3'd1;
    localparam logic [KIND_W-1:0] K_DEL_AFTER = 3'd2;
    localparam logic [KIND_W-1:0] K_DEL_BEFORE = 3'd3;
    localparam logic [KIND_W-1:0] K_INS_AFTER = 3'd4;
    localparam logic [KIND_W-1:0] K_INS_BEFORE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTARGET = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONEIGHBOUR = 3'd4;

endpackage

// File: rtl/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: request channel, result
// channel, APB capacity register and the entry memory with its sequencer.
// Depends on bole_pkg.
//
// Usage: a request (kind, target value, new value) is a transfer on
// i_valid/o_ready; one result (status, removed value, entry count) follows
// as a transfer on o_valid/i_ready. The list lives in a one-port-read,
// one-port-write synchronous memory; slot 0 is the front.
// Steps of a request: it is decoded; the search walks the entries (read
// port, one entry per cycle); a shift moves entries one at a time (read
// one, write the neighbor); a new value is written; the result register
// is loaded. Requests refused or ignored at decode go straight to the
// result register. The longest requests are an insert before or a delete
// before that finds its target.
// One request is in flight at a time; o_ready is high whenever the
// sequencer is idle, even while a result waits in the output register.
// If the receiver stalls, the finished result of the next request waits
// in the sequencer until the output register frees.
// Reset empties the list and sets capacity to 3; memory is not cleared,
// since only slots below the entry count are used. The user, not the
// block, must write capacity (APB byte address 0) only while it is idle.
module bounded_ordered_list_engine
#(
    parameter int DEPTH = bole_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bole_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [bole_pkg::KIND_W-1:0]        i_kind,
    input  logic [VALUE_WIDTH-1:0]             i_target_value,
    input  logic [VALUE_WIDTH-1:0]             i_new_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [bole_pkg::STATUS_W-1:0]      o_status,
    output logic [VALUE_WIDTH-1:0]             o_removed_value,
    output logic [bole_pkg::COUNT_W-1:0]       o_entry_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bole_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bole_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bole_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import bole_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_TAKE,
        S_PUT,
        S_PUTV,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [VALUE_WIDTH-1:0] r_tgt, n_tgt;
    logic [VALUE_WIDTH-1:0] r_new, n_new;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [CAP_W-1:0] r_cap, n_cap;
    logic r_ovalid, n_ovalid;
    logic [STATUS_W-1:0] r_ostatus, n_ostatus;
    logic [VALUE_WIDTH-1:0] r_orem, n_orem;
    logic [COUNT_W-1:0] r_ocount, n_ocount;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd;
    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [VALUE_WIDTH-1:0] mem_wd;

    logic [CW-1:0] eff_cap;
    logic full;
    logic hit;
    logic last;
    logic [CW-1:0] ins_pos;
    logic cfg_wr;
    logic cfg_sel;

    assign cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
    assign cfg_wr = psel && penable && pwrite && cfg_sel;
    assign pready = 1'b1;
    assign prdata = cfg_sel ? APB_DATA_W'(r_cap) : '0;

    always_comb begin
        if (32'(r_cap) > 32'(DEPTH)) begin
            eff_cap = CW'(DEPTH);
        end else begin
            eff_cap = CW'(r_cap);
        end
    end

    assign full = (r_count >= eff_cap);
    assign hit = (r_rd == r_tgt);
    assign last = ((r_idx + 1'b1) >= r_count);
    assign ins_pos = (r_kind == K_INS_AFTER) ? r_idx + 1'b1 : r_idx;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_status = r_ostatus;
    assign o_removed_value = r_orem;
    assign o_entry_count = r_ocount;

    always_comb begin
        n_state = r_state;
        n_kind = r_kind;
        n_tgt = r_tgt;
        n_new = r_new;
        n_rem = r_rem;
        n_status = r_status;
        n_count = r_count;
        n_idx = r_idx;
        n_pos = r_pos;
        n_cap = cfg_wr ? pwdata[CAP_W-1:0] : r_cap;
        n_ovalid = r_ovalid && !i_ready;
        n_ostatus = r_ostatus;
        n_orem = r_orem;
        n_ocount = r_ocount;
        mem_we = 1'b0;
        mem_wa = r_idx[AW-1:0];
        mem_wd = r_rd;
        mem_ra = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind = i_kind;
                    n_tgt = i_target_value;
                    n_new = i_new_value;
                    n_rem = '0;
                    n_status = ST_OK;
                    n_idx = '0;
                    n_state = S_DONE;
                    case (i_kind)
                        K_INS_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                n_pos = '0;
                                n_state = S_PUTV;
                            end else begin
                                n_pos = '0;
                                n_idx = r_count - 1'b1;
                                mem_ra = AW'(r_count - 1'b1);
                                n_state = S_PUT;
                            end
                        end
                        K_REM_REAR: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_pos = r_count - 1'b1;
                                n_idx = r_count - 1'b1;
                                mem_ra = AW'(r_count - 1'b1);
                                n_state = S_TAKE;
                            end
                        end
                        K_DEL_AFTER, K_DEL_BEFORE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        K_INS_AFTER, K_INS_BEFORE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    case (r_kind)
                        K_DEL_AFTER: begin
                            if (last) begin
                                n_status = ST_NONEIGHBOUR;
                                n_state = S_DONE;
                            end else begin
                                n_pos = r_idx + 1'b1;
                                n_idx = r_idx + 1'b1;
                                mem_ra = AW'(r_idx + 1'b1);
                                n_state = S_TAKE;
                            end
                        end
                        K_DEL_BEFORE: begin
                            if (r_idx == '0) begin
                                n_status = ST_NONEIGHBOUR;
                                n_state = S_DONE;
                            end else begin
                                n_pos = r_idx - 1'b1;
                                n_idx = r_idx - 1'b1;
                                mem_ra = AW'(r_idx - 1'b1);
                                n_state = S_TAKE;
                            end
                        end
                        default: begin
                            n_pos = ins_pos;
                            if (ins_pos == r_count) begin
                                n_state = S_PUTV;
                            end else begin
                                n_idx = r_count - 1'b1;
                                mem_ra = AW'(r_count - 1'b1);
                                n_state = S_PUT;
                            end
                        end
                    endcase
                end else if (last) begin
                    if (r_kind inside {K_DEL_AFTER, K_DEL_BEFORE}) begin
                        n_status = ST_NONEIGHBOUR;
                    end else begin
                        n_status = ST_NOTARGET;
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    mem_ra = AW'(r_idx + 1'b1);
                end
            end
            S_TAKE: begin
                if (r_idx == r_pos) begin
                    n_rem = r_rd;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = AW'(r_idx - 1'b1);
                end
                if (last) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    mem_ra = AW'(r_idx + 1'b1);
                end
            end
            S_PUT: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_idx + 1'b1);
                if (r_idx == r_pos) begin
                    n_state = S_PUTV;
                end else begin
                    n_idx = r_idx - 1'b1;
                    mem_ra = AW'(r_idx - 1'b1);
                end
            end
            S_PUTV: begin
                mem_we = 1'b1;
                mem_wa = r_pos[AW-1:0];
                mem_wd = r_new;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ostatus = r_status;
                    n_orem = r_rem;
                    n_ocount = COUNT_W'(r_count);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap <= CAP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cap <= n_cap;
            r_ovalid <= n_ovalid;
        end
        r_kind <= n_kind;
        r_tgt <= n_tgt;
        r_new <= n_new;
        r_rem <= n_rem;
        r_status <= n_status;
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_ostatus <= n_ostatus;
        r_orem <= n_orem;
        r_ocount <= n_ocount;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !mem_we)
        else $error("memory written outside a list update");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_TAKE && r_state != S_PUTV) |=> $stable(r_count))
        else $error("entry count moved outside a take or put");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result loaded without a finished request");

endmodule

// File: test/tb_bounded_ordered_list_engine.sv
// Self-checking testbench for bounded_ordered_list_engine: directed and random list requests
// are predicted by a queue-based list tracker and every result transfer is compared in order.
// Depends on bole_pkg and the engine RTL only.
module tb_bounded_ordered_list_engine;
    import bole_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int VALUE_W = VALUE_WIDTH_DEF;
    localparam logic [KIND_W-1:0] K_UNUSED_6 = 3'd6;
    localparam logic [KIND_W-1:0] K_UNUSED_7 = 3'd7;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS = 150;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  removed;
        logic [COUNT_W-1:0]  count;
    } t_list_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [KIND_W-1:0]     i_kind = '0;
    logic [VALUE_W-1:0]    i_target_value = '0;
    logic [VALUE_W-1:0]    i_new_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [VALUE_W-1:0]    o_removed_value;
    logic [COUNT_W-1:0]    o_entry_count;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // list tracker: index 0 is the front
    logic [VALUE_W-1:0] list_model[$];
    logic [CAP_W-1:0]   capacity_reg = CAP_RESET;
    t_list_result       pending_results[$];
    t_list_result       want;

    bit idle_en = 1'b1;
    int holds_requested = 0;
    int holds_served = 0;
    int rx_wait = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int configs_written = 0;
    int status_seen[8];

    bounded_ordered_list_engine DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(50, 20);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return VALUE_W'($urandom_range(7));
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    function automatic int find_target(input logic [VALUE_W-1:0] v);
        foreach (list_model[i]) begin
            if (list_model[i] == v) return i;
        end
        return -1;
    endfunction

    function automatic t_list_result apply_request(input logic [KIND_W-1:0] kind,
                                                   input logic [VALUE_W-1:0] tgt,
                                                   input logic [VALUE_W-1:0] nv);
        t_list_result r;
        int pos;
        int cap;
        r.status = ST_OK;
        r.removed = '0;
        cap = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        pos = find_target(tgt);
        case (kind)
            K_INS_FRONT: begin
                if (list_model.size() >= cap) r.status = ST_FULL;
                else list_model.push_front(nv);
            end
            K_REM_REAR: begin
                if (list_model.size() == 0) r.status = ST_EMPTY;
                else r.removed = list_model.pop_back();
            end
            K_DEL_AFTER: begin
                if (list_model.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos < 0 || pos + 1 >= list_model.size()) begin
                    r.status = ST_NONEIGHBOUR;
                end else begin
                    r.removed = list_model[pos + 1];
                    list_model.delete(pos + 1);
                end
            end
            K_DEL_BEFORE: begin
                if (list_model.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos <= 0) begin
                    r.status = ST_NONEIGHBOUR;
                end else begin
                    r.removed = list_model[pos - 1];
                    list_model.delete(pos - 1);
                end
            end
            K_INS_AFTER, K_INS_BEFORE: begin
                if (list_model.size() == 0) r.status = ST_EMPTY;
                else if (list_model.size() >= cap) r.status = ST_FULL;
                else if (pos < 0) r.status = ST_NOTARGET;
                else list_model.insert((kind == K_INS_AFTER) ? pos + 1 : pos, nv);
            end
            default: ;
        endcase
        r.count = COUNT_W'(list_model.size());
        return r;
    endfunction

    // one request transfer, then an optional idle gap on the request side
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [VALUE_W-1:0] tgt,
                                input logic [VALUE_W-1:0] nv);
        int gap;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_target_value <= tgt;
        i_new_value <= nv;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_request(kind, tgt, nv));
        requests_sent++;
        gap = idle_en ? random_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // targets mostly hit a held entry so the after/before paths do real work
    task automatic send_random_request(output bit counted);
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] tgt;
        int r;
        r = $urandom_range(99);
        if (r < 18) kind = K_INS_FRONT;
        else if (r < 32) kind = K_REM_REAR;
        else if (r < 46) kind = K_DEL_AFTER;
        else if (r < 60) kind = K_DEL_BEFORE;
        else if (r < 78) kind = K_INS_AFTER;
        else if (r < 96) kind = K_INS_BEFORE;
        else if (r < 98) kind = K_UNUSED_6;
        else kind = K_UNUSED_7;
        if (list_model.size() != 0 && $urandom_range(99) < 70)
            tgt = list_model[$urandom_range(list_model.size() - 1)];
        else
            tgt = pick_value();
        send_request(kind, tgt, pick_value());
        counted = (kind != K_UNUSED_6 && kind != K_UNUSED_7);
    endtask

    task automatic wait_results_drained();
        if (i_valid) i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_CAPACITY, 2'b00};
        pwdata <= APB_DATA_W'(cap);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        capacity_reg = cap;
        configs_written++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_empty_list();
        send_request(K_REM_REAR, '0, '0);
        send_request(K_DEL_AFTER, '1, '0);
        send_request(K_DEL_BEFORE, '0, '1);
        send_request(K_INS_BEFORE, '0, '1);
        send_request(K_UNUSED_6, '1, '1);
    endtask

    // at the reset capacity of three
    task automatic test_basic_operations();
        send_request(K_INS_FRONT, '0, '1);
        send_request(K_INS_FRONT, '1, '0);
        send_request(K_INS_BEFORE, '1, VALUE_W'(5));
        send_request(K_INS_FRONT, '0, VALUE_W'(7));
        send_request(K_INS_AFTER, VALUE_W'(9), VALUE_W'(7));   // full wins over no target
        send_request(K_DEL_AFTER, '1, '0);                     // rear has no successor
        send_request(K_DEL_BEFORE, '0, '0);                    // front has no predecessor
        send_request(K_DEL_AFTER, '0, '0);
        send_request(K_INS_AFTER, VALUE_W'(9), VALUE_W'(7));
        send_request(K_REM_REAR, '0, '0);
    endtask

    task automatic test_capacity_limits();
        write_capacity(4'd0);
        send_request(K_INS_FRONT, '0, VALUE_W'(1));
        wait_results_drained();
        write_capacity(4'd15);
        for (int i = 0; i < 8; i++)
            send_request(K_INS_FRONT, '0, i[0] ? '1 : VALUE_W'($urandom()));
        // shrink below the held count: entries stay, inserts refused
        write_capacity(4'd1);
        send_request(K_INS_BEFORE, '0, '1);
    endtask

    task automatic test_backpressure();
        bit counted;
        write_capacity(4'd8);
        idle_en = 1'b0;
        holds_requested++;
        repeat (24) send_random_request(counted);
        wait_results_drained();
        idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] caps [6];
        bit counted;
        int done;
        caps = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd6, 4'd0};
        caps[5] = CAP_W'($urandom_range(15));
        for (int p = 0; p < 6; p++) begin
            write_capacity(caps[p]);
            idle_en = (p != 2);
            done = 0;
            while (done < PHASE_ITEMS) begin
                send_random_request(counted);
                if (counted) begin
                    done++;
                    if (done % 50 == 25) wait_results_drained();
                end
            end
        end
        idle_en = 1'b1;
    endtask

    // result side: random stalls, long hold-offs on request, in-order checking
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result transfer: status %0d removed %h count %0d",
                         $time, o_status, o_removed_value, o_entry_count);
            end else begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (o_status !== want.status) begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_removed_value !== want.removed) begin
                    mismatch_count++;
                    $display("%0t: removed_value expected %h actual %h",
                             $time, want.removed, o_removed_value);
                end
                if (o_entry_count !== want.count) begin
                    mismatch_count++;
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, o_entry_count);
                end
            end
        end
        if (holds_served != holds_requested) begin
            holds_served++;
            rx_wait = HOLD_CYCLES;
        end else if (rx_wait > 0) begin
            rx_wait--;
        end else if (idle_en) begin
            rx_wait = random_gap();
        end
        i_ready <= (rx_wait == 0);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL bounded_ordered_list_engine");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_basic_operations();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests, checked %0d results across %0d capacity writes, %0d mismatches",
                 requests_sent, results_checked, configs_written, mismatch_count);
        $display("Status mix: ok %0d, full %0d, empty %0d, no target %0d, no neighbour %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_NOTARGET], status_seen[ST_NONEIGHBOUR]);
        if (mismatch_count == 0) begin
            $display("PASS bounded_ordered_list_engine");
        end else begin
            $display("FAIL bounded_ordered_list_engine");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/bole_pkg.sv
rtl/bounded_ordered_list_engine.sv
test/tb_bounded_ordered_list_engine.sv
